[design/keypad_code_lock_assert.svh]
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KCL_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("keypad_code_lock: same-cycle check failed");

// next-cycle implication, checked outside reset
`define KCL_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("keypad_code_lock: next-cycle check failed");

`endif

[design/kcl_pkg.sv]
package kcl_pkg;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		MODE_LOCKED   = 2'd0,
		MODE_ENTERING = 2'd1,
		MODE_WINDOW   = 2'd2,
		MODE_OPEN     = 2'd3
	} lock_mode_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_DIGIT  = 3'd1,
		EV_ACCEPT = 3'd2,
		EV_REJECT = 3'd3,
		EV_OPEN   = 3'd4,
		EV_EXPIRE = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_LATCH = 2'd1,
		OP_TILT  = 2'd2,
		OP_TICK  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_CODE      = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_WINDOW    = 2'd2
	} reg_idx_t;

	localparam logic [9:0]  THRESHOLD_RST = 10'd512;
	localparam logic [15:0] WINDOW_RST    = 16'd1000;

	localparam logic [3:0] KEY_ENTER_A = 4'd7;
	localparam logic [3:0] KEY_ENTER_B = 4'd14;

	typedef struct packed {
		logic [15:0] lock_code;
		logic [9:0]  tilt_threshold;
		logic [15:0] unlock_window;
	} cfg_t;

	typedef struct packed {
		logic       is_digit;
		logic       is_enter;
		logic [3:0] digit;
	} key_t;

	// raw keypad encoder code -> digit / enter / nothing
	function automatic key_t key_decode(input logic [3:0] code);
		key_t k;
		k = '0;
		case (code)
			4'd0:  begin k.is_digit = 1'b1; k.digit = 4'd7; end
			4'd1:  begin k.is_digit = 1'b1; k.digit = 4'd8; end
			4'd2:  begin k.is_digit = 1'b1; k.digit = 4'd9; end
			4'd4:  begin k.is_digit = 1'b1; k.digit = 4'd4; end
			4'd5:  begin k.is_digit = 1'b1; k.digit = 4'd5; end
			4'd6:  begin k.is_digit = 1'b1; k.digit = 4'd6; end
			4'd8:  begin k.is_digit = 1'b1; k.digit = 4'd1; end
			4'd9:  begin k.is_digit = 1'b1; k.digit = 4'd2; end
			4'd10: begin k.is_digit = 1'b1; k.digit = 4'd3; end
			4'd13: begin k.is_digit = 1'b1; k.digit = 4'd0; end
			KEY_ENTER_A, KEY_ENTER_B: begin k.is_enter = 1'b1; end
			default: begin k = '0; end
		endcase
		return k;
	endfunction

endpackage

[design/kcl_apb_regs.sv]
module kcl_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output kcl_pkg::cfg_t              cfg
);
	import kcl_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_code      <= '0;
			cfg_q.tilt_threshold <= THRESHOLD_RST;
			cfg_q.unlock_window  <= WINDOW_RST;
		end else if (wr) begin
			case (idx)
				REG_CODE:      cfg_q.lock_code      <= pwdata[15:0];
				REG_THRESHOLD: cfg_q.tilt_threshold <= pwdata[9:0];
				REG_WINDOW:    cfg_q.unlock_window  <= pwdata[15:0];
				default: begin end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CODE:      prdata = {16'd0, cfg_q.lock_code};
			REG_THRESHOLD: prdata = {22'd0, cfg_q.tilt_threshold};
			REG_WINDOW:    prdata = {16'd0, cfg_q.unlock_window};
			default:       prdata = '0;
		endcase
	end

endmodule

[design/keypad_code_lock.sv]
// keypad_code_lock
// A request passes through the input register, then the result register.
// Throughput: 1 request per cycle when out_stall is low; the input register
// doubles as a skid stage: a request is taken while a finished result waits.
// Reset (arst_n low, async): lock locked, entry buffer and timer cleared,
// registers to code 0, threshold 512, window 1000; both stages empty.
module keypad_code_lock #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [3:0]                 key_code,
	input  logic [9:0]                 tilt_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 lock_state,
	output logic [2:0]                 event_res,
	output logic [2:0]                 digits_entered,
	output logic                       theft_alarm,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import kcl_pkg::*;

	`include "keypad_code_lock_assert.svh"

	localparam int CW = $clog2(CODE_DIGITS + 1);

	cfg_t cfg;

	kcl_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic       valid_s1;
	opcode_t    opcode_s1;
	logic [3:0] key_s1;
	logic [9:0] tilt_s1;

	// result stage
	logic       out_valid_q;
	lock_mode_t res_mode_q;
	event_t     res_event_q;
	logic [2:0] res_cnt_q;
	logic       res_alarm_q;

	// lock state
	lock_mode_t mode_q, mode_d;
	logic [3:0] entry_q [CODE_DIGITS];
	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0] tmr_q, tmr_d;

	logic   advance, fire;
	key_t   kd;
	logic   full, match;
	logic   dig_we, clr_entry;
	logic   alarm;
	event_t ev;
	logic [15:0] tmr_dec;
	logic [4*CODE_DIGITS-1:0] want;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode_t'(opcode);
			key_s1    <= key_code;
			tilt_s1   <= tilt_sample;
		end
	end

	assign kd    = key_decode(key_s1);
	assign full  = (cnt_q == CW'(CODE_DIGITS));
	assign want  = (4*CODE_DIGITS)'(cfg.lock_code);
	assign alarm = (opcode_s1 == OP_TILT) && (tilt_s1 > cfg.tilt_threshold);
	assign tmr_dec = (tmr_q != 16'd0) ? tmr_q - 16'd1 : 16'd0;

	always_comb begin
		match = full;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (entry_q[i] != want[4*i +: 4]) begin
				match = 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		tmr_d     = tmr_q;
		dig_we    = 1'b0;
		clr_entry = 1'b0;
		case (opcode_s1)
			OP_KEY: begin
				if (mode_q == MODE_LOCKED || mode_q == MODE_ENTERING) begin
					if (kd.is_enter) begin
						clr_entry = 1'b1;
						cnt_d     = '0;
						if (match) begin
							mode_d = MODE_WINDOW;
							tmr_d  = cfg.unlock_window;
						end else begin
							mode_d = MODE_LOCKED;
						end
					end else if (kd.is_digit && !full) begin
						dig_we = 1'b1;
						cnt_d  = cnt_q + CW'(1);
						mode_d = MODE_ENTERING;
					end
				end
			end
			OP_LATCH: begin
				if (mode_q == MODE_WINDOW) begin
					mode_d = MODE_OPEN;
					tmr_d  = '0;
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_WINDOW) begin
					tmr_d = tmr_dec;
					if (tmr_dec == 16'd0) begin
						mode_d = MODE_LOCKED;
					end
				end
			end
			default: begin end
		endcase
	end

	// event output
	always_comb begin
		ev = EV_NONE;
		case (opcode_s1)
			OP_KEY: begin
				if (mode_q == MODE_LOCKED || mode_q == MODE_ENTERING) begin
					if (kd.is_enter) begin
						ev = match ? EV_ACCEPT : EV_REJECT;
					end else if (kd.is_digit && !full) begin
						ev = EV_DIGIT;
					end
				end
			end
			OP_LATCH: begin
				if (mode_q == MODE_WINDOW) begin
					ev = EV_OPEN;
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_WINDOW && tmr_dec == 16'd0) begin
					ev = EV_EXPIRE;
				end
			end
			default: ev = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LOCKED;
			cnt_q  <= '0;
			tmr_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			tmr_q  <= tmr_d;
		end
	end

	for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				entry_q[g] <= '0;
			end else if (fire) begin
				if (clr_entry) begin
					entry_q[g] <= '0;
				end else if (dig_we && cnt_q == CW'(g)) begin
					entry_q[g] <= kd.digit;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_mode_q  <= mode_d;
			res_event_q <= ev;
			res_cnt_q   <= 3'(cnt_d);
			res_alarm_q <= alarm;
		end
	end

	assign out_valid      = out_valid_q;
	assign lock_state     = res_mode_q;
	assign event_res      = res_event_q;
	assign digits_entered = res_cnt_q;
	assign theft_alarm    = res_alarm_q;

	`KCL_ASSERT_IMP(a_buf_empty_unlocked, clk, arst_n,
		(mode_q == MODE_WINDOW || mode_q == MODE_OPEN), (cnt_q == '0))
	`KCL_ASSERT_NXT(a_open_sticky, clk, arst_n, (mode_q == MODE_OPEN), (mode_q == MODE_OPEN))
	`KCL_ASSERT_NXT(a_s1_held, clk, arst_n, (valid_s1 && !advance), (valid_s1 && $stable(key_s1)))
	`KCL_ASSERT_NXT(a_accept_loads_timer, clk, arst_n, (fire && ev == EV_ACCEPT),
		(mode_q == MODE_WINDOW && tmr_q == $past(cfg.unlock_window)))

endmodule

[sim/keypad_code_lock_checker.sv]
`timescale 1ns / 1ps

module keypad_code_lock_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [3:0]                 key_code,
	input  logic [9:0]                 tilt_sample,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 lock_state,
	input  logic [2:0]                 event_res,
	input  logic [2:0]                 digits_entered,
	input  logic                       theft_alarm,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kcl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	output int                         fail_count,
	output int                         outstanding
);
	import kcl_pkg::*;

	localparam int         LEN      = 4;
	localparam logic [4:0] KEY_VOID = 5'd16;
	localparam logic [4:0] KEY_GO   = 5'd17;

	typedef struct packed {
		lock_mode_t mode;
		event_t     ev;
		logic [2:0] count;
		logic       alarm;
	} lock_result_t;

	logic [15:0]  code_reg;
	logic [9:0]   thr_reg;
	logic [15:0]  win_reg;
	logic [3:0]   buf_digits [LEN];
	logic [2:0]   buf_count;
	lock_mode_t   mode;
	logic [15:0]  timer;
	lock_result_t awaited [$];

	function automatic logic [4:0] key_value(logic [3:0] raw);
		case (raw)
			4'd0:  return 5'd7;
			4'd1:  return 5'd8;
			4'd2:  return 5'd9;
			4'd4:  return 5'd4;
			4'd5:  return 5'd5;
			4'd6:  return 5'd6;
			4'd8:  return 5'd1;
			4'd9:  return 5'd2;
			4'd10: return 5'd3;
			4'd13: return 5'd0;
			KEY_ENTER_A, KEY_ENTER_B: return KEY_GO;
			default: return KEY_VOID;
		endcase
	endfunction

	function automatic lock_result_t advance_lock(opcode_t op, logic [3:0] raw, logic [9:0] tilt);
		lock_result_t r;
		logic [4:0]   k;
		logic         hit;
		int           i;
		r.ev = EV_NONE;
		r.alarm = 1'b0;
		case (op)
			OP_KEY: begin
				k = key_value(raw);
				if (mode == MODE_LOCKED || mode == MODE_ENTERING) begin
					if (k == KEY_GO) begin
						hit = (buf_count == LEN);
						for (i = 0; i < LEN; i++)
							if (buf_digits[i] != code_reg[4*i +: 4])
								hit = 1'b0;
						if (hit) begin
							mode = MODE_WINDOW;
							timer = win_reg;
							r.ev = EV_ACCEPT;
						end else begin
							mode = MODE_LOCKED;
							r.ev = EV_REJECT;
						end
						for (i = 0; i < LEN; i++)
							buf_digits[i] = '0;
						buf_count = '0;
					end else if (k != KEY_VOID && buf_count < LEN) begin
						buf_digits[buf_count[1:0]] = k[3:0];
						buf_count = buf_count + 3'd1;
						mode = MODE_ENTERING;
						r.ev = EV_DIGIT;
					end
				end
			end
			OP_LATCH: begin
				if (mode == MODE_WINDOW) begin
					mode = MODE_OPEN;
					timer = '0;
					r.ev = EV_OPEN;
				end
			end
			OP_TILT: r.alarm = (tilt > thr_reg);
			default: begin
				if (mode == MODE_WINDOW) begin
					if (timer != 0)
						timer = timer - 16'd1;
					if (timer == 0) begin
						mode = MODE_LOCKED;
						r.ev = EV_EXPIRE;
					end
				end
			end
		endcase
		r.mode = mode;
		r.count = buf_count;
		return r;
	endfunction

	task automatic report(string field, int got, int want);
		fail_count++;
		if (fail_count <= 30)
			$display("ERROR %0t: %s got %0d, expected %0d", $time, field, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_result_t got;
		lock_result_t want;
		int           i;
		if (!arst_n) begin
			code_reg = '0;
			thr_reg = THRESHOLD_RST;
			win_reg = WINDOW_RST;
			for (i = 0; i < LEN; i++)
				buf_digits[i] = '0;
			buf_count = '0;
			mode = MODE_LOCKED;
			timer = '0;
			awaited.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {lock_state, event_res, digits_entered, theft_alarm};
				if (awaited.size() == 0) begin
					report("result with no request, state", got.mode, -1);
				end else begin
					want = awaited.pop_front();
					if (got.mode !== want.mode)
						report("lock_state", got.mode, want.mode);
					if (got.ev !== want.ev)
						report("event_res", got.ev, want.ev);
					if (got.count !== want.count)
						report("digits_entered", got.count, want.count);
					if (got.alarm !== want.alarm)
						report("theft_alarm", got.alarm, want.alarm);
				end
			end
			if (in_valid && !in_stall)
				awaited.push_back(advance_lock(opcode_t'(opcode), key_code, tilt_sample));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_CODE:      code_reg = pwdata[15:0];
					REG_THRESHOLD: thr_reg = pwdata[9:0];
					REG_WINDOW:    win_reg = pwdata[15:0];
					default: ;
				endcase
			end
			outstanding <= awaited.size();
		end
	end

endmodule

[sim/keypad_code_lock_tb.sv]
`timescale 1ns / 1ps

module keypad_code_lock_tb;
	import kcl_pkg::*;

	localparam int          LEN         = 4;
	localparam int          TARGET      = 1050;
	localparam int          STALL_MAX   = 8;
	localparam int          HOLD_CYCLES = 64;
	localparam int          WATCHDOG    = 2000;
	localparam logic [15:0] DEAD_KEYS   = {4'd15, 4'd12, 4'd11, 4'd3};

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic [1:0]          opcode      = '0;
	logic [3:0]          key_code    = '0;
	logic [9:0]          tilt_sample = '0;
	logic                out_stall   = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [ADDR_W-1:0]   paddr       = '0;
	logic [31:0]         pwdata      = '0;
	logic                in_stall;
	logic                out_valid;
	logic [1:0]          lock_state;
	logic [2:0]          event_res;
	logic [2:0]          digits_entered;
	logic                theft_alarm;
	logic [31:0]         prdata;
	logic                pready;
	int                  fail_count;
	int                  outstanding;

	bit          tx_burst  = 1'b0;
	bit          rx_burst  = 1'b0;
	bit          rx_hold   = 1'b0;
	bit          in_window = 1'b0;
	int          ticks_left;
	int          sent      = 0;
	int          idle_cycles = 0;
	logic [15:0] cur_code;
	logic [9:0]  cur_thr;
	logic [15:0] cur_window;
	logic [3:0]  typed [$];

	always #5 clk = ~clk;

	keypad_code_lock i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.key_code       (key_code),
		.tilt_sample    (tilt_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lock_state     (lock_state),
		.event_res      (event_res),
		.digits_entered (digits_entered),
		.theft_alarm    (theft_alarm),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	keypad_code_lock_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.key_code       (key_code),
		.tilt_sample    (tilt_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lock_state     (lock_state),
		.event_res      (event_res),
		.digits_entered (digits_entered),
		.theft_alarm    (theft_alarm),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	function automatic logic [3:0] digit_key(int d);
		case (d)
			0: return 4'd13;
			1: return 4'd8;
			2: return 4'd9;
			3: return 4'd10;
			4: return 4'd4;
			5: return 4'd5;
			6: return 4'd6;
			7: return 4'd0;
			8: return 4'd1;
			default: return 4'd2;
		endcase
	endfunction

	function automatic logic [15:0] rand_bcd();
		logic [15:0] c;
		int          i;
		for (i = 0; i < LEN; i++)
			c[4*i +: 4] = 4'($urandom_range(0, 9));
		return c;
	endfunction

	function automatic logic [9:0] pick_tilt();
		case ($urandom_range(0, 5))
			0: return cur_thr;
			1: return cur_thr + 10'd1;
			2: return cur_thr - 10'd1;
			3: return '0;
			4: return '1;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] code, logic [9:0] thr, logic [15:0] win);
		apb_write(REG_CODE, 32'(code));
		apb_write(REG_THRESHOLD, 32'(thr));
		apb_write(REG_WINDOW, 32'(win));
		cur_code = code;
		cur_thr = thr;
		cur_window = win;
	endtask

	task automatic push_req(opcode_t op, logic [3:0] key, logic [9:0] tilt);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key_code <= (op == OP_KEY) ? key : 4'($urandom_range(0, 15));
		tilt_sample <= (op == OP_TILT) ? tilt : 10'($urandom_range(0, 1023));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic digit_req(int d);
		if (!in_window && typed.size() < LEN)
			typed.push_back(4'(d));
		push_req(OP_KEY, digit_key(d), '0);
	endtask

	task automatic enter_req();
		bit hit;
		int i;
		if (!in_window) begin
			hit = (typed.size() == LEN);
			if (hit)
				for (i = 0; i < LEN; i++)
					if (typed[i] != cur_code[4*i +: 4])
						hit = 1'b0;
			if (hit) begin
				in_window = 1'b1;
				ticks_left = cur_window;
			end
			typed.delete();
		end
		push_req(OP_KEY, $urandom_range(0, 1) ? KEY_ENTER_A : KEY_ENTER_B, '0);
	endtask

	task automatic tick_req();
		if (in_window) begin
			ticks_left--;
			if (ticks_left == 0)
				in_window = 1'b0;
		end
		push_req(OP_TICK, '0, '0);
	endtask

	// a latch inside the window would open the lock for good, so keep it out
	task automatic noise_req();
		int k;
		k = $urandom_range(0, 3);
		case ($urandom_range(0, 3))
			0: push_req(OP_KEY, DEAD_KEYS[4*k +: 4], '0);
			1: push_req(OP_TILT, '0, pick_tilt());
			2: tick_req();
			default: begin
				if (in_window)
					push_req(OP_TILT, '0, pick_tilt());
				else
					push_req(OP_LATCH, '0, '0);
			end
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int n;
		forever begin
			if (rx_hold) begin
				rx_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("keypad_code_lock: mismatch");
			$finish;
		end
	end

	initial begin
		int          i;
		int          s;
		int          d;
		int          n_dig;
		int          phase;
		bit          right;
		logic [3:0]  want;
		logic [15:0] code;
		logic [9:0]  thr;
		logic [15:0] win;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(16'h4321, 10'd512, 16'd3);
		for (i = 0; i < 4; i++)
			push_req(OP_KEY, DEAD_KEYS[4*i +: 4], '0);
		push_req(OP_LATCH, '0, '0);
		tick_req();
		enter_req();
		push_req(OP_TILT, '0, 10'd512);
		push_req(OP_TILT, '0, 10'd513);
		push_req(OP_TILT, '0, 10'd0);
		push_req(OP_TILT, '0, 10'd1023);
		digit_req(1);
		digit_req(2);
		digit_req(3);
		digit_req(4);
		digit_req(9);
		enter_req();
		digit_req(7);
		enter_req();
		push_req(OP_KEY, DEAD_KEYS[3:0], '0);
		tick_req();
		tick_req();
		tick_req();
		digit_req(1);
		digit_req(2);
		digit_req(3);
		digit_req(5);
		enter_req();
		drain();

		phase = 0;
		while (sent < TARGET) begin
			drain();
			case ($urandom_range(0, 4))
				0: code = 16'h0000;
				1: code = 16'h9999;
				2: code = 16'($urandom_range(0, 39321));
				default: code = rand_bcd();
			endcase
			case ($urandom_range(0, 3))
				0: thr = 10'd0;
				1: thr = 10'd1023;
				default: thr = 10'($urandom_range(0, 1023));
			endcase
			win = ($urandom_range(0, 2) == 0) ? 16'd1 : 16'($urandom_range(2, 6));
			set_config(code, thr, win);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if (phase % 3 == 1) begin
				rx_hold = 1'b1;
				tx_burst = 1'b1;
			end
			phase++;
			for (s = 0; s < 12 && sent < TARGET; s++) begin
				n_dig = ($urandom_range(0, 3) != 0) ? LEN : $urandom_range(0, 6);
				right = ($urandom_range(0, 9) < 7);
				for (i = 0; i < n_dig; i++) begin
					if ($urandom_range(0, 4) == 0)
						noise_req();
					want = cur_code[4*(i % LEN) +: 4];
					if (right && i < LEN && want <= 4'd9)
						d = want;
					else
						d = $urandom_range(0, 9);
					digit_req(d);
				end
				if ($urandom_range(0, 9) != 0)
					enter_req();
				while (in_window) begin
					case ($urandom_range(0, 5))
						0, 1, 2: tick_req();
						3: digit_req($urandom_range(0, 9));
						4: enter_req();
						default: noise_req();
					endcase
				end
			end
		end

		// longest window, then open the lock; open holds until reset
		drain();
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		set_config(rand_bcd(), 10'($urandom_range(0, 1023)), 16'hFFFF);
		for (i = 0; i < LEN; i++)
			digit_req(cur_code[4*i +: 4]);
		enter_req();
		tick_req();
		tick_req();
		push_req(OP_TILT, '0, pick_tilt());
		push_req(OP_LATCH, '0, '0);
		push_req(OP_TICK, '0, '0);
		push_req(OP_LATCH, '0, '0);
		digit_req(5);
		enter_req();
		push_req(OP_TILT, '0, pick_tilt());
		drain();

		if (fail_count == 0)
			$display("keypad_code_lock: match");
		else
			$display("keypad_code_lock: mismatch");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/kcl_pkg.sv
design/kcl_apb_regs.sv
design/keypad_code_lock.sv
sim/keypad_code_lock_checker.sv
sim/keypad_code_lock_tb.sv
